### rtl/core/qafb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quorum acknowledgement feedback tracker.
// No dependencies; imported by every module of the block.
package qafb_pkg;

	localparam int POS_W     = 64;
	localparam int STAMP_W   = 63;
	localparam int XID_W     = 64;
	localparam int IN_IDX_W  = 3;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 264;
	localparam int M_TDATA_W = 256;
	localparam int M_TUSER_W = 2;

	localparam int I_IDX_LSB   = 0;
	localparam int I_POS_LSB   = I_IDX_LSB + IN_IDX_W;
	localparam int I_STAMP_LSB = I_POS_LSB + POS_W;
	localparam int I_XID_LSB   = I_STAMP_LSB + STAMP_W;
	localparam int I_CAT_LSB   = I_XID_LSB + XID_W;

	localparam int O_POS_LSB   = 0;
	localparam int O_STAMP_LSB = O_POS_LSB + POS_W;
	localparam int O_XID_LSB   = O_STAMP_LSB + STAMP_W;
	localparam int O_CAT_LSB   = O_XID_LSB + XID_W;
	localparam int O_USED_W    = O_CAT_LSB + XID_W;

	localparam int U_FLUSH   = 0;
	localparam int U_STANDBY = 1;

	localparam logic [XID_W-1:0] XID_NONE = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_COUNT  = 2'd0,
		REG_QUORUM_SIZE = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} seq_state_t;

	typedef struct packed {
		logic [XID_W-1:0]   cat;
		logic [XID_W-1:0]   xid;
		logic [STAMP_W-1:0] stamp;
		logic [POS_W-1:0]   pos;
	} node_entry_t;

	typedef struct packed {
		logic cand;
		logic minp;
		logic rowend;
	} scan_tag_t;

endpackage

### rtl/core/qafb_node_mem.sv
`timescale 1ns / 1ps
// Per-node acknowledgement store: one write port, one registered read port.
// Entries never written read as zero through per-entry valid bits. Uses qafb_pkg.
module qafb_node_mem
	import qafb_pkg::*;
#(
	parameter int DEPTH  = 8,
	parameter int ADDR_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  node_entry_t       wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output node_entry_t       rd_data
);

	node_entry_t            mem [DEPTH];
	logic [DEPTH-1:0]       valid_q;
	node_entry_t            rd_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

### rtl/core/quorum_ack_feedback_tracker.sv
`timescale 1ns / 1ps
// Top level of the quorum acknowledgement feedback tracker: sequencer, rank
// selection and minimum datapath around qafb_node_mem. Uses qafb_pkg.
//
// channel   dir  handshake           payload
// cfg       in   cfg_valid/cfg_ready cfg_index, cfg_data
// s_axis    in   s_tvalid/s_tready   s_tdata (acknowledgement)
// m_axis    out  m_tvalid/m_tready   m_tdata, m_tuser (report)
//
// An acknowledgement is processed with one memory read per cycle: a candidate
// read followed by a pass over all nodes for each candidate, the first pass
// also forming the minimum. At count zero no scan or drain runs.
// Reset clears the valid bits of the node store at once; no clearing pass.
// A report waiting on m_tready holds the result stage; a new acknowledgement
// is still taken once the sequencer is back in idle.
module quorum_ack_feedback_tracker
	import qafb_pkg::*;
#(
	parameter int MAX_NODES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// node_index, acked_position, standby_stamp, oldest_xid, oldest_catalog_xid
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// quorum_position, combined_stamp, combined_xid, combined_catalog_xid
	output logic [M_TDATA_W-1:0] m_tdata,
	// send_flush, send_standby
	output logic [M_TUSER_W-1:0] m_tuser
);

	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int IXC_W  = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

	logic [CFG_W-1:0]    node_count_q;
	logic [CFG_W-1:0]    quorum_q;
	logic [CMP_W-1:0]    nc_ext;
	logic [CMP_W-1:0]    qz_ext;
	logic [CMP_W-1:0]    cnt_ext;
	logic [CMP_W-1:0]    q_eff;
	logic [CNT_W-1:0]    count;
	logic [CNT_W-1:0]    last_idx;
	logic [CNT_W-1:0]    rank_k;

	seq_state_t          state_q, state_d;
	logic [CNT_W-1:0]    i_q, i_d;
	logic [CNT_W-1:0]    j_q, j_d;
	logic                cand_ph_q, cand_ph_d;
	logic                issue;
	scan_tag_t           tag;
	logic                load_out;
	logic                s_accept;

	logic                vld_s1;
	scan_tag_t           tag_s1;

	node_entry_t         in_entry;
	logic [IN_IDX_W-1:0] in_idx;
	logic                wr_en;
	logic [ADDR_W-1:0]   rd_addr;
	node_entry_t         rd;

	logic [POS_W-1:0]    cand_q;
	logic [CNT_W-1:0]    lt_q, le_q, lt_nx, le_nx;
	logic [POS_W-1:0]    sel_q;
	logic                found_q;
	logic [XID_W-1:0]    cx_q, cc_q;
	logic [STAMP_W-1:0]  cs_q;

	logic [POS_W-1:0]    rep_pos_q;
	logic [STAMP_W-1:0]  rep_stamp_q;
	logic [XID_W-1:0]    rep_xid_q, rep_cat_q;
	logic                do_flush, do_standby;
	logic [POS_W-1:0]    new_pos;

	logic                m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;
	logic [M_TUSER_W-1:0] m_user_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(1);
			quorum_q     <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_NODE_COUNT) begin
				node_count_q <= cfg_data;
			end else if (cfg_index == REG_QUORUM_SIZE) begin
				quorum_q <= cfg_data;
			end
		end
	end

	always_comb begin
		nc_ext  = CMP_W'(node_count_q);
		count   = (nc_ext > CMP_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(nc_ext);
		cnt_ext = CMP_W'(count);
		qz_ext  = CMP_W'(quorum_q);
		if (qz_ext == '0) begin
			q_eff = CMP_W'(1);
		end else if (qz_ext > cnt_ext) begin
			q_eff = cnt_ext;
		end else begin
			q_eff = qz_ext;
		end
		rank_k   = CNT_W'(cnt_ext - q_eff);
		last_idx = count - CNT_W'(1);
	end

	// input side
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	assign in_idx         = s_tdata[I_IDX_LSB +: IN_IDX_W];
	assign in_entry.pos   = s_tdata[I_POS_LSB +: POS_W];
	assign in_entry.stamp = s_tdata[I_STAMP_LSB +: STAMP_W];
	assign in_entry.xid   = s_tdata[I_XID_LSB +: XID_W];
	assign in_entry.cat   = s_tdata[I_CAT_LSB +: XID_W];

	assign wr_en   = s_accept && (IXC_W'(in_idx) < IXC_W'(MAX_NODES));
	assign rd_addr = cand_ph_q ? i_q[ADDR_W-1:0] : j_q[ADDR_W-1:0];

	qafb_node_mem #(
		.DEPTH  (MAX_NODES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (ADDR_W'(in_idx)),
		.wr_data (in_entry),
		.rd_addr (rd_addr),
		.rd_data (rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		i_d        = i_q;
		j_d        = j_q;
		cand_ph_d  = cand_ph_q;
		issue      = 1'b0;
		tag        = '0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					i_d       = '0;
					j_d       = '0;
					cand_ph_d = 1'b1;
					state_d   = (count == '0) ? ST_RESULT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (cand_ph_q) begin
					tag.cand  = 1'b1;
					cand_ph_d = 1'b0;
					j_d       = '0;
				end else begin
					tag.minp = (i_q == '0);
					if (j_q == last_idx) begin
						tag.rowend = 1'b1;
						if (i_q == last_idx) begin
							state_d = ST_DRAIN;
						end else begin
							i_d       = i_q + CNT_W'(1);
							cand_ph_d = 1'b1;
						end
					end else begin
						j_d = j_q + CNT_W'(1);
					end
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!m_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			cand_ph_q <= 1'b0;
			vld_s1    <= 1'b0;
			tag_s1    <= '0;
		end else begin
			i_q       <= i_d;
			j_q       <= j_d;
			cand_ph_q <= cand_ph_d;
			vld_s1    <= issue;
			tag_s1    <= tag;
		end
	end

	// rank selection and minimum over the read stream
	assign lt_nx = lt_q + CNT_W'(rd.pos < cand_q);
	assign le_nx = le_q + CNT_W'(rd.pos <= cand_q);

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cx_q <= XID_NONE;
			cc_q <= XID_NONE;
			cs_q <= '0;
		end else if (vld_s1) begin
			if (tag_s1.cand) begin
				cand_q <= rd.pos;
				lt_q   <= '0;
				le_q   <= '0;
			end else begin
				lt_q <= lt_nx;
				le_q <= le_nx;
				if (tag_s1.rowend && !found_q && (lt_nx <= rank_k) && (rank_k < le_nx)) begin
					sel_q <= cand_q;
				end
				if (tag_s1.minp && (rd.stamp != '0)) begin
					if (rd.xid < cx_q) begin
						cx_q <= rd.xid;
					end
					if (rd.cat < cc_q) begin
						cc_q <= rd.cat;
					end
					if ((rd.xid < cx_q) || (rd.cat < cc_q)) begin
						cs_q <= rd.stamp;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (s_accept) begin
			found_q <= 1'b0;
		end else if (vld_s1 && !tag_s1.cand && tag_s1.rowend && (lt_nx <= rank_k)
				&& (rank_k < le_nx)) begin
			found_q <= 1'b1;
		end
	end

	// report decision
	always_comb begin
		do_flush   = found_q && (sel_q > rep_pos_q);
		new_pos    = do_flush ? sel_q : rep_pos_q;
		do_standby = (cs_q != '0)
			&& ((cs_q != rep_stamp_q) || (cx_q != rep_xid_q) || (cc_q != rep_cat_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_pos_q   <= '0;
			rep_stamp_q <= '0;
			rep_xid_q   <= '0;
			rep_cat_q   <= '0;
		end else if (load_out) begin
			rep_pos_q <= new_pos;
			if (do_standby) begin
				rep_stamp_q <= cs_q;
				rep_xid_q   <= cx_q;
				rep_cat_q   <= cc_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {{(M_TDATA_W - O_USED_W){1'b0}}, cc_q, cx_q, cs_q, new_pos};
			m_user_q <= {do_standby, do_flush};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

### rtl/core/qafb_checker.sv
`timescale 1ns / 1ps
// Port-level checks for quorum_ack_feedback_tracker, attached by bind.
// Uses qafb_pkg for field offsets.
module qafb_checker
	import qafb_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("report transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("report payload changed while stalled");

	a_standby_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[U_STANDBY] |-> m_tdata[O_STAMP_LSB +: STAMP_W] != '0)
		else $error("standby report with zero stamp");

	a_flush_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[U_FLUSH] |-> m_tdata[O_POS_LSB +: POS_W] != '0)
		else $error("flush report at position zero");

	a_empty_feedback: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[O_STAMP_LSB +: STAMP_W] == '0)
		|-> (m_tdata[O_XID_LSB +: XID_W] == XID_NONE)
			&& (m_tdata[O_CAT_LSB +: XID_W] == XID_NONE))
		else $error("combined minimum without stamp");

endmodule

bind quorum_ack_feedback_tracker qafb_checker u_qafb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
